// ===== src/b64d_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared constants and types of the streaming base64 decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

    localparam int ALPHA_SIZE = 64;
    localparam int NUM_WORDS  = 8;
    localparam int CHAR_W     = 8;
    localparam int WORD_W     = NUM_WORDS * CHAR_W;
    localparam int SEXTET_W   = 6;
    localparam int INDEX_W    = $clog2(NUM_WORDS);
    localparam int MAX_OUT    = 3;
    localparam int COUNT_W    = 2;

    localparam logic [CHAR_W-1:0] DEFAULT_PAD_CHAR = 8'd61;

    // Position of a character inside its group of four.
    localparam logic [1:0] POS_FIRST  = 2'd0;
    localparam logic [1:0] POS_SECOND = 2'd1;
    localparam logic [1:0] POS_THIRD  = 2'd2;
    localparam logic [1:0] POS_FOURTH = 2'd3;

    typedef struct packed {
        logic [CHAR_W-1:0] data_byte;
        logic              byte_valid;
        logic              end_of_input;
        logic              decode_error;
    } result_t;

    typedef struct packed {
        logic                found;
        logic [SEXTET_W-1:0] idx;
    } lookup_t;

endpackage

// ===== src/b64d_lookup.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_lookup
// Parallel alphabet search: the lowest matching alphabet entry wins.
// ----------------------------------------------------------------------------
module b64d_lookup (
    input  logic [b64d_pkg::ALPHA_SIZE*b64d_pkg::CHAR_W-1:0] alphabet,
    input  logic [b64d_pkg::CHAR_W-1:0]                      char_in,
    output b64d_pkg::lookup_t                                result
);
    import b64d_pkg::*;

    logic [ALPHA_SIZE-1:0] match;
    logic [ALPHA_SIZE-1:0] lowest;
    logic [SEXTET_W-1:0]   idx;

    always_comb
    begin
        for (int i = 0; i < ALPHA_SIZE; i++)
        begin
            match[i] = (alphabet[i*CHAR_W +: CHAR_W] == char_in);
        end
    end

    // Isolate the lowest set bit, then encode the one-hot vector.
    assign lowest = match & (~match + {{(ALPHA_SIZE-1){1'b0}}, 1'b1});

    always_comb
    begin
        idx = '0;
        for (int i = 0; i < ALPHA_SIZE; i++)
        begin
            if (lowest[i])
            begin
                idx = idx | SEXTET_W'(i);
            end
        end
    end

    assign result.found = |match;
    assign result.idx   = idx;

endmodule

// ===== src/base64_decoder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_decoder_core
// Streaming base64 decoder with a programmable alphabet and padding checks.
// ----------------------------------------------------------------------------
// Each input item is one encoded character. It is decoded in the cycle it is
// accepted, and its results (zero to three items) are loaded into a
// three-entry result buffer that drains one item per cycle on the output
// channel while out_ready is high. A new character is taken only while the
// buffer is empty or holds one result that leaves in the same cycle. So a
// character that yields no result or a single result lets the next one
// follow in the next cycle if out_ready is high. A final character that
// yields two bytes holds the input until the first has left; one that
// completes a group of four yields three bytes, and the next character
// waits while two drain. Full groups are limited by the single result port.
// With end_of_input the decoder reports decode_error; when that is set the
// consumer discards every byte of the stream. The alphabet is written through
// wr_en, wr_index and wr_data, eight bytes per word, lowest byte first. The
// user must write it only while the block is idle; nothing enforces this.
// ----------------------------------------------------------------------------
module base64_decoder_core #(
    parameter logic [b64d_pkg::CHAR_W-1:0] PAD_CHAR = b64d_pkg::DEFAULT_PAD_CHAR
) (
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           wr_en,
    input  logic [b64d_pkg::INDEX_W-1:0]   wr_index,
    input  logic [b64d_pkg::WORD_W-1:0]    wr_data,

    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [b64d_pkg::CHAR_W-1:0]    char_in,
    input  logic                           last_char,

    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [b64d_pkg::CHAR_W-1:0]    data_byte,
    output logic                           byte_valid,
    output logic                           end_of_input,
    output logic                           decode_error
);
    import b64d_pkg::*;

    // Alphabet registers and their flat view for the search.
    logic [WORD_W-1:0] alpha_reg [NUM_WORDS];
    logic [ALPHA_SIZE*CHAR_W-1:0] alpha_flat;

    // Group state.
    logic [1:0]          pos_reg, pos_next;
    logic [SEXTET_W-1:0] store_reg [MAX_OUT];
    logic [SEXTET_W-1:0] store_next [MAX_OUT];
    logic                third_pad_reg, third_pad_next;
    logic                third_found_reg, third_found_next;
    logic                err_reg, err_next;

    // Result buffer; entry 0 is the head shown on the output.
    result_t             res_reg [MAX_OUT];
    result_t             res_next [MAX_OUT];
    logic [COUNT_W-1:0]  cnt_reg, cnt_next;

    lookup_t             lk;
    logic                is_pad;
    logic                in_fire;
    logic                out_fire;
    logic [COUNT_W-1:0]  n_bytes;
    logic [CHAR_W-1:0]   bytes [MAX_OUT];
    result_t             load [MAX_OUT];
    logic [COUNT_W-1:0]  load_cnt;

    always_comb
    begin
        for (int w = 0; w < NUM_WORDS; w++)
        begin
            alpha_flat[w*WORD_W +: WORD_W] = alpha_reg[w];
        end
    end

    b64d_lookup u_lookup (
        .alphabet (alpha_flat),
        .char_in  (char_in),
        .result   (lk)
    );

    assign is_pad   = (char_in == PAD_CHAR);
    assign out_valid = (cnt_reg != '0);
    assign out_fire  = out_valid && out_ready;
    // The buffer must be empty, or about to empty, before a new item loads.
    assign in_ready  = (cnt_reg == '0) || ((cnt_reg == COUNT_W'(1)) && out_ready);
    assign in_fire   = in_valid && in_ready;

    assign data_byte    = res_reg[0].data_byte;
    assign byte_valid   = res_reg[0].byte_valid;
    assign end_of_input = res_reg[0].end_of_input;
    assign decode_error = res_reg[0].decode_error;

    // The fourth character supplies the last sextet directly from the search.
    assign bytes[0] = {store_reg[0], store_reg[1][5:4]};
    assign bytes[1] = {store_reg[1][3:0], store_reg[2][5:2]};
    assign bytes[2] = {store_reg[2][1:0], lk.idx};

    // Per-character decode and group bookkeeping.
    always_comb
    begin
        pos_next         = pos_reg;
        third_pad_next   = third_pad_reg;
        third_found_next = third_found_reg;
        err_next         = err_reg;
        n_bytes          = '0;
        for (int i = 0; i < MAX_OUT; i++)
        begin
            store_next[i] = store_reg[i];
        end

        if (pos_reg != POS_FOURTH)
        begin
            if (pos_reg == POS_THIRD)
            begin
                third_pad_next   = is_pad;
                third_found_next = lk.found;
            end
            else if (!lk.found)
            begin
                err_next = 1'b1;
            end
            for (int i = 0; i < MAX_OUT; i++)
            begin
                if (pos_reg == 2'(i))
                begin
                    store_next[i] = lk.idx;
                end
            end
            // A stream may only end on the fourth character of a group.
            if (last_char)
            begin
                err_next = 1'b1;
            end
            pos_next = pos_reg + 2'd1;
        end
        else
        begin
            if (last_char)
            begin
                if (third_pad_reg)
                begin
                    if (is_pad)
                    begin
                        n_bytes = COUNT_W'(1);
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                else if (!third_found_reg)
                begin
                    err_next = 1'b1;
                end
                else if (is_pad)
                begin
                    n_bytes = COUNT_W'(2);
                end
                else if (lk.found)
                begin
                    n_bytes = COUNT_W'(3);
                end
                else
                begin
                    err_next = 1'b1;
                end
            end
            else if (third_found_reg && lk.found)
            begin
                n_bytes = COUNT_W'(3);
            end
            else
            begin
                err_next = 1'b1;
            end
            pos_next = POS_FIRST;
        end

        // Results of this character.
        for (int i = 0; i < MAX_OUT; i++)
        begin
            load[i].data_byte    = bytes[i];
            load[i].byte_valid   = 1'b1;
            load[i].end_of_input = last_char && (n_bytes == COUNT_W'(i + 1));
            load[i].decode_error = 1'b0;
        end
        load_cnt = err_next ? '0 : n_bytes;
        if (last_char && err_next)
        begin
            load[0].data_byte    = '0;
            load[0].byte_valid   = 1'b0;
            load[0].end_of_input = 1'b1;
            load[0].decode_error = 1'b1;
            load_cnt             = COUNT_W'(1);
        end

        // The end of a stream starts the next one from a clean state.
        if (last_char)
        begin
            pos_next         = POS_FIRST;
            third_pad_next   = 1'b0;
            third_found_next = 1'b0;
            err_next         = 1'b0;
        end
    end

    // Result buffer: shift out the head, then load a newly accepted item.
    always_comb
    begin
        for (int i = 0; i < MAX_OUT; i++)
        begin
            res_next[i] = res_reg[i];
        end
        cnt_next = cnt_reg;
        if (out_fire)
        begin
            for (int i = 0; i < MAX_OUT - 1; i++)
            begin
                res_next[i] = res_reg[i + 1];
            end
            cnt_next = cnt_reg - COUNT_W'(1);
        end
        if (in_fire)
        begin
            for (int i = 0; i < MAX_OUT; i++)
            begin
                res_next[i] = load[i];
            end
            cnt_next = load_cnt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < NUM_WORDS; w++)
            begin
                alpha_reg[w] <= '0;
            end
        end
        else if (wr_en)
        begin
            alpha_reg[wr_index] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= POS_FIRST;
            third_pad_reg   <= 1'b0;
            third_found_reg <= 1'b0;
            err_reg         <= 1'b0;
            cnt_reg         <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (in_fire)
            begin
                pos_reg         <= pos_next;
                third_pad_reg   <= third_pad_next;
                third_found_reg <= third_found_next;
                err_reg         <= err_next;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_OUT; i++)
        begin
            res_reg[i] <= res_next[i];
            if (in_fire)
            begin
                store_reg[i] <= store_next[i];
            end
        end
    end

endmodule
